FILE: sv/phased_interval_response_resolve_macros.svh
// assertion macros shared by the resolver modules
// expects clk and rst_n in the scope where a macro is used
`ifndef PHASED_INTERVAL_RESPONSE_RESOLVE_MACROS_SVH
`define PHASED_INTERVAL_RESPONSE_RESOLVE_MACROS_SVH

// same-cycle implication
`define PIRR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pirr_pkg.sv
// types and constants of the phased interval response resolver
// no dependencies
package pirr_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned RESP_W  = 16;
  localparam int unsigned PHASE_W = 6;
  localparam int unsigned NPH_W   = 7;
  localparam int unsigned RCNT_W  = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned STEP_W  = 3;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_PLAN   = 2'd0;
  localparam logic [1:0] REG_PHASES = 2'd1;
  localparam logic [1:0] REG_RCOUNT = 2'd2;

  localparam logic [RCNT_W-1:0] RCOUNT_RST = 5'd2;
  localparam logic [NPH_W-1:0]  MAX_PHASES = 7'd64;
  localparam logic [RESP_W-1:0] RESP_FAIL  = 16'hFFFF;
  localparam logic [STEP_W-1:0] ALIGN_LAST = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN,
    S_CHECK,
    S_ALIGN,
    S_SUM,
    S_SA_GO,
    S_SA_WAIT,
    S_SB_GO,
    S_SB_WAIT,
    S_SZ_GO,
    S_SZ_WAIT,
    S_DONE
  } pirr_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_STEP,
    T_CMP,
    T_LAST
  } pirr_tstate_t;

  typedef struct packed {
    logic              start;
    logic              entry0_only;
    logic [DATA_W-1:0] key;
  } pirr_srch_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [RESP_W-1:0] response;
  } pirr_srch_rsp_t;

endpackage

FILE: sv/phased_interval_response_resolve.sv
// top level of the phased interval response resolver
// depends on pirr_pkg, pirr_table and the resolver assertion macros
//
//  port group   direction  handshake            carries
//  in_*         in         in_valid/in_ready    table write or phase value
//  out_*        out        out_valid/out_ready  response, resolved, next phase, failed
//  apb          in/out     psel/penable/pready  plan mask, phase count, response count
//
// a table write is a single accepted item; a phase value drops k plan bits, one per cycle,
// k = start phase on a new key, then aligns, sums and runs two binary searches of s steps,
// s = ceil(log2(searched entries)); the two searches share the table's single read port
// synchronous active-low reset; the table has no reset and needs no clearing pass
// the next item is taken while a result waits in the output register

`include "phased_interval_response_resolve_macros.svh"

module phased_interval_response_resolve #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [pirr_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [pirr_pkg::DATA_W-1:0]   in_entry_bound,
  input  logic [pirr_pkg::RESP_W-1:0]   in_entry_response,
  input  logic [pirr_pkg::DATA_W-1:0]   in_phase_value,
  input  logic                          in_new_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pirr_pkg::RESP_W-1:0]   out_response,
  output logic                          out_resolved,
  output logic [pirr_pkg::PHASE_W-1:0]  out_next_phase,
  output logic                          out_failed,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pirr_pkg::ADDR_W-1:0]   paddr,
  input  logic [pirr_pkg::DATA_W-1:0]   pwdata,
  output logic [pirr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

  // configuration
  logic [pirr_pkg::DATA_W-1:0] plan_mask_r, plan_mask_nxt;
  logic [pirr_pkg::NPH_W-1:0]  phase_count_r, phase_count_nxt;
  logic [pirr_pkg::RCNT_W-1:0] response_count_r, response_count_nxt;
  logic                        cfg_wr;
  logic [1:0]                  reg_sel;

  // resolver state
  pirr_pkg::pirr_state_t state_r, state_nxt;
  logic [pirr_pkg::DATA_W-1:0]  rem_r, rem_nxt;
  logic [pirr_pkg::DATA_W-1:0]  loc_r, loc_nxt;
  logic [pirr_pkg::DATA_W-1:0]  known_r, known_nxt;
  logic [pirr_pkg::PHASE_W-1:0] cur_r, cur_nxt;
  logic                         wrap_r, wrap_nxt;

  // per-item working registers
  logic [pirr_pkg::NPH_W-1:0]   n_r, n_nxt;
  logic [pirr_pkg::PHASE_W-1:0] start_r, start_nxt;
  logic [pirr_pkg::PHASE_W-1:0] cnt_r, cnt_nxt;
  logic [pirr_pkg::DATA_W-1:0]  pval_r, pval_nxt;
  logic [pirr_pkg::DATA_W-1:0]  least_r, least_nxt;
  logic [pirr_pkg::DATA_W-1:0]  algn_r, algn_nxt;
  logic [pirr_pkg::DATA_W-1:0]  val_r, val_nxt;
  logic [pirr_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [pirr_pkg::RESP_W-1:0]  resp_a_r, resp_a_nxt;

  // pending result and output register
  logic [pirr_pkg::RESP_W-1:0]  pend_resp_r, pend_resp_nxt;
  logic                         pend_res_r, pend_res_nxt;
  logic [pirr_pkg::PHASE_W-1:0] pend_next_r, pend_next_nxt;
  logic                         pend_fail_r, pend_fail_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [pirr_pkg::RESP_W-1:0]  out_resp_r, out_resp_nxt;
  logic                         out_res_r, out_res_nxt;
  logic [pirr_pkg::PHASE_W-1:0] out_next_r, out_next_nxt;
  logic                         out_fail_r, out_fail_nxt;

  logic                         in_acc;
  logic [pirr_pkg::NPH_W-1:0]   n_acc;
  logic [pirr_pkg::NPH_W-1:0]   n_less2;
  logic [pirr_pkg::PHASE_W-1:0] start_acc;
  logic                         check_fail;
  logic                         out_free;
  logic [5:0]                   sh_w;
  logic [pirr_pkg::DATA_W-1:0]  low_mask;
  logic [pirr_pkg::NPH_W-1:0]   ph7;
  logic                         wrap_now;
  logic [pirr_pkg::PHASE_W-1:0] ph6;
  logic                         walk_fail;

  logic [16:0]     wr_idx_w;
  logic            tbl_wr;
  pirr_pkg::pirr_srch_req_t srch_req;
  pirr_pkg::pirr_srch_rsp_t srch_rsp;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[4:3];

  always_comb begin
    plan_mask_nxt      = plan_mask_r;
    phase_count_nxt    = phase_count_r;
    response_count_nxt = response_count_r;
    if (cfg_wr) begin
      case (reg_sel)
        pirr_pkg::REG_PLAN:   plan_mask_nxt      = pwdata;
        pirr_pkg::REG_PHASES: phase_count_nxt    = pwdata[pirr_pkg::NPH_W-1:0];
        pirr_pkg::REG_RCOUNT: response_count_nxt = pwdata[pirr_pkg::RCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pirr_pkg::REG_PLAN:   prdata = plan_mask_r;
      pirr_pkg::REG_PHASES: prdata = {57'd0, phase_count_r};
      pirr_pkg::REG_RCOUNT: prdata = {59'd0, response_count_r};
      default:              prdata = '0;
    endcase
  end

  // ---------------- table ----------------
  assign in_ready = (state_r == pirr_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_idx_w = {13'd0, in_entry_index};
  assign tbl_wr   = in_acc && !in_op && (wr_idx_w < DEPTH_W);

  assign srch_req.start = (state_r == pirr_pkg::S_SA_GO) || (state_r == pirr_pkg::S_SB_GO) ||
                          (state_r == pirr_pkg::S_SZ_GO);
  assign srch_req.entry0_only = (state_r == pirr_pkg::S_SZ_GO);
  // second search: unknown locator bits all set
  assign srch_req.key = (state_r == pirr_pkg::S_SB_GO) ? (loc_r | ~known_r) : loc_r;

  pirr_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_wr),
    .wr_idx   (wr_idx_w[IW-1:0]),
    .wr_bound (in_entry_bound),
    .wr_resp  (in_entry_response),
    .rcount   (response_count_r),
    .req      (srch_req),
    .rsp      (srch_rsp)
  );

  // ---------------- phase walk ----------------
  assign n_acc     = (phase_count_r > pirr_pkg::MAX_PHASES) ? pirr_pkg::MAX_PHASES
                                                             : phase_count_r;
  assign n_less2   = n_acc - 7'd2;
  assign start_acc = (n_acc >= 7'd2) ? n_less2[pirr_pkg::PHASE_W-1:0] : '0;
  assign check_fail = wrap_r && (cur_r == start_r);
  assign out_free  = !out_valid_r || out_ready;

  // align by halving: 32, 16, 8, 4, 2, 1
  assign sh_w     = 6'd32 >> step_r;
  assign low_mask = ~({pirr_pkg::DATA_W{1'b1}} << sh_w);

  assign ph7       = {1'b0, cur_r} + 7'd1;
  assign wrap_now  = (ph7 >= n_r);
  assign ph6       = wrap_now ? '0 : ph7[pirr_pkg::PHASE_W-1:0];
  assign walk_fail = (wrap_r || wrap_now) && (ph6 == start_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pirr_pkg::S_IDLE: begin
        if (in_valid && in_op) begin
          state_nxt = (n_acc == '0) ? pirr_pkg::S_SZ_GO : pirr_pkg::S_PLAN;
        end
      end
      pirr_pkg::S_PLAN: begin
        if (cnt_r == '0) state_nxt = pirr_pkg::S_CHECK;
      end
      pirr_pkg::S_CHECK: begin
        state_nxt = check_fail ? pirr_pkg::S_DONE : pirr_pkg::S_ALIGN;
      end
      pirr_pkg::S_ALIGN: begin
        if (step_r == pirr_pkg::ALIGN_LAST) state_nxt = pirr_pkg::S_SUM;
      end
      pirr_pkg::S_SUM:   state_nxt = pirr_pkg::S_SA_GO;
      pirr_pkg::S_SA_GO: state_nxt = pirr_pkg::S_SA_WAIT;
      pirr_pkg::S_SA_WAIT: begin
        if (srch_rsp.done) state_nxt = pirr_pkg::S_SB_GO;
      end
      pirr_pkg::S_SB_GO: state_nxt = pirr_pkg::S_SB_WAIT;
      pirr_pkg::S_SB_WAIT: begin
        if (srch_rsp.done) state_nxt = pirr_pkg::S_DONE;
      end
      pirr_pkg::S_SZ_GO: state_nxt = pirr_pkg::S_SZ_WAIT;
      pirr_pkg::S_SZ_WAIT: begin
        if (srch_rsp.done) state_nxt = pirr_pkg::S_DONE;
      end
      pirr_pkg::S_DONE: begin
        if (out_free) state_nxt = pirr_pkg::S_IDLE;
      end
      default: state_nxt = pirr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rem_nxt       = rem_r;
    loc_nxt       = loc_r;
    known_nxt     = known_r;
    cur_nxt       = cur_r;
    wrap_nxt      = wrap_r;
    n_nxt         = n_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    pval_nxt      = pval_r;
    least_nxt     = least_r;
    algn_nxt      = algn_r;
    val_nxt       = val_r;
    step_nxt      = step_r;
    resp_a_nxt    = resp_a_r;
    pend_resp_nxt = pend_resp_r;
    pend_res_nxt  = pend_res_r;
    pend_next_nxt = pend_next_r;
    pend_fail_nxt = pend_fail_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_resp_nxt  = out_resp_r;
    out_res_nxt   = out_res_r;
    out_next_nxt  = out_next_r;
    out_fail_nxt  = out_fail_r;
    case (state_r)
      pirr_pkg::S_IDLE: begin
        if (in_valid && in_op && (n_acc != '0)) begin
          n_nxt     = n_acc;
          start_nxt = start_acc;
          pval_nxt  = in_phase_value;
          cnt_nxt   = '0;
          if (in_new_key) begin
            rem_nxt   = plan_mask_r;
            cnt_nxt   = start_acc;
            loc_nxt   = '0;
            known_nxt = (plan_mask_r - 64'd1) & ~plan_mask_r;
            cur_nxt   = start_acc;
            wrap_nxt  = 1'b0;
          end else if ({1'b0, cur_r} >= n_acc) begin
            wrap_nxt = 1'b1;
            cur_nxt  = '0;
            rem_nxt  = plan_mask_r;
          end
        end
      end
      pirr_pkg::S_PLAN: begin
        // drop the lowest plan bit once per skipped phase
        if (cnt_r != '0) begin
          rem_nxt = rem_r & (rem_r - 64'd1);
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      pirr_pkg::S_CHECK: begin
        if (check_fail) begin
          pend_resp_nxt = pirr_pkg::RESP_FAIL;
          pend_res_nxt  = 1'b0;
          pend_next_nxt = '0;
          pend_fail_nxt = 1'b1;
        end else begin
          least_nxt = rem_r & (~rem_r + 64'd1);
          algn_nxt  = rem_r & (~rem_r + 64'd1);
          rem_nxt   = rem_r & (rem_r - 64'd1);
          val_nxt   = pval_r;
          step_nxt  = '0;
        end
      end
      pirr_pkg::S_ALIGN: begin
        if (step_r == '0) begin
          known_nxt = known_r | ((rem_r - least_r) & ~rem_r);
        end
        if ((algn_r & low_mask) == '0) begin
          algn_nxt = algn_r >> sh_w;
          val_nxt  = val_r << sh_w;
        end
        step_nxt = step_r + 3'd1;
      end
      pirr_pkg::S_SUM: begin
        if (least_r != '0) loc_nxt = loc_r + val_r;
      end
      pirr_pkg::S_SA_WAIT: begin
        if (srch_rsp.done) resp_a_nxt = srch_rsp.response;
      end
      pirr_pkg::S_SB_WAIT: begin
        if (srch_rsp.done) begin
          if (srch_rsp.response == resp_a_r) begin
            pend_resp_nxt = resp_a_r;
            pend_res_nxt  = 1'b1;
            pend_next_nxt = '0;
            pend_fail_nxt = 1'b0;
          end else begin
            if (wrap_now) begin
              wrap_nxt = 1'b1;
              rem_nxt  = plan_mask_r;
            end
            cur_nxt       = ph6;
            pend_resp_nxt = walk_fail ? pirr_pkg::RESP_FAIL : '0;
            pend_res_nxt  = 1'b0;
            pend_next_nxt = walk_fail ? '0 : ph6;
            pend_fail_nxt = walk_fail;
          end
        end
      end
      pirr_pkg::S_SZ_WAIT: begin
        if (srch_rsp.done) begin
          pend_resp_nxt = srch_rsp.response;
          pend_res_nxt  = 1'b1;
          pend_next_nxt = '0;
          pend_fail_nxt = 1'b0;
        end
      end
      pirr_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_resp_nxt  = pend_resp_r;
          out_res_nxt   = pend_res_r;
          out_next_nxt  = pend_next_r;
          out_fail_nxt  = pend_fail_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_response   = out_resp_r;
  assign out_resolved   = out_res_r;
  assign out_next_phase = out_next_r;
  assign out_failed     = out_fail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_mask_r      <= '0;
      phase_count_r    <= '0;
      response_count_r <= pirr_pkg::RCOUNT_RST;
      state_r          <= pirr_pkg::S_IDLE;
      rem_r            <= '0;
      loc_r            <= '0;
      known_r          <= '0;
      cur_r            <= '0;
      wrap_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      plan_mask_r      <= plan_mask_nxt;
      phase_count_r    <= phase_count_nxt;
      response_count_r <= response_count_nxt;
      state_r          <= state_nxt;
      rem_r            <= rem_nxt;
      loc_r            <= loc_nxt;
      known_r          <= known_nxt;
      cur_r            <= cur_nxt;
      wrap_r           <= wrap_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    start_r     <= start_nxt;
    cnt_r       <= cnt_nxt;
    pval_r      <= pval_nxt;
    least_r     <= least_nxt;
    algn_r      <= algn_nxt;
    val_r       <= val_nxt;
    step_r      <= step_nxt;
    resp_a_r    <= resp_a_nxt;
    pend_resp_r <= pend_resp_nxt;
    pend_res_r  <= pend_res_nxt;
    pend_next_r <= pend_next_nxt;
    pend_fail_r <= pend_fail_nxt;
    out_resp_r  <= out_resp_nxt;
    out_res_r   <= out_res_nxt;
    out_next_r  <= out_next_nxt;
    out_fail_r  <= out_fail_nxt;
  end

  `PIRR_ASSERT_NEXT(a_lookup_busy, in_acc && in_op, state_r != pirr_pkg::S_IDLE, "lookup item did not start work")
  `PIRR_ASSERT_IMPL(a_search_free, srch_req.start, !srch_rsp.busy, "search requested while table busy")
  `PIRR_ASSERT_IMPL(a_out_excl, out_valid, !(out_resolved && out_failed), "result both resolved and failed")
  `PIRR_ASSERT_IMPL(a_fail_code, out_valid && out_failed, (out_response == pirr_pkg::RESP_FAIL) && (out_next_phase == '0), "malformed failure result")

endmodule

FILE: sv/pirr_table.sv
// bound/response table memory with a binary search sequencer
// depends on pirr_pkg and the resolver assertion macros
`include "phased_interval_response_resolve_macros.svh"

module pirr_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_idx,
  input  logic [pirr_pkg::DATA_W-1:0]   wr_bound,
  input  logic [pirr_pkg::RESP_W-1:0]   wr_resp,
  input  logic [pirr_pkg::RCNT_W-1:0]   rcount,
  input  pirr_pkg::pirr_srch_req_t      req,
  output pirr_pkg::pirr_srch_rsp_t      rsp
);

  localparam int unsigned IW    = $clog2(TABLE_DEPTH);
  localparam int unsigned WORD_W = pirr_pkg::DATA_W + pirr_pkg::RESP_W;
  localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

  logic [WORD_W-1:0] tbl_mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [IW-1:0]     rd_addr;

  pirr_pkg::pirr_tstate_t state_r, state_nxt;
  logic [IW-1:0]               lo_r, lo_nxt;
  logic [IW-1:0]               hi_r, hi_nxt;
  logic [IW-1:0]               mid_r, mid_nxt;
  logic [pirr_pkg::DATA_W-1:0] key_r, key_nxt;

  logic [16:0]   rc_w;
  logic [16:0]   hi_full;
  logic [IW-1:0] hi_init;
  logic [IW:0]   mid_sum;
  logic [IW-1:0] mid;

  // searched span: count clamped to 1..TABLE_DEPTH
  assign rc_w = {12'd0, rcount};
  always_comb begin
    if (rc_w == 17'd0) begin
      hi_full = 17'd0;
    end else if (rc_w > DEPTH_W) begin
      hi_full = DEPTH_W - 17'd1;
    end else begin
      hi_full = rc_w - 17'd1;
    end
  end
  assign hi_init = hi_full[IW-1:0];

  // upper midpoint
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + {{IW{1'b0}}, 1'b1};
  assign mid     = mid_sum[IW:1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_idx] <= {wr_bound, wr_resp};
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pirr_pkg::T_IDLE: begin
        if (req.start) state_nxt = pirr_pkg::T_STEP;
      end
      pirr_pkg::T_STEP: begin
        state_nxt = (lo_r < hi_r) ? pirr_pkg::T_CMP : pirr_pkg::T_LAST;
      end
      pirr_pkg::T_CMP:  state_nxt = pirr_pkg::T_STEP;
      pirr_pkg::T_LAST: state_nxt = pirr_pkg::T_IDLE;
      default:          state_nxt = pirr_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    mid_nxt = mid_r;
    key_nxt = key_r;
    rd_addr = lo_r;
    case (state_r)
      pirr_pkg::T_IDLE: begin
        if (req.start) begin
          lo_nxt  = '0;
          hi_nxt  = req.entry0_only ? '0 : hi_init;
          key_nxt = req.key;
        end
      end
      pirr_pkg::T_STEP: begin
        // the final read fetches the chosen entry's response
        rd_addr = (lo_r < hi_r) ? mid : lo_r;
        mid_nxt = mid;
      end
      pirr_pkg::T_CMP: begin
        if (key_r >= rd_data_r[WORD_W-1:pirr_pkg::RESP_W]) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r - {{(IW-1){1'b0}}, 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.busy     = (state_r != pirr_pkg::T_IDLE);
  assign rsp.done     = (state_r == pirr_pkg::T_LAST);
  assign rsp.response = rd_data_r[pirr_pkg::RESP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pirr_pkg::T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
  end

  `PIRR_ASSERT_IMPL(a_wr_idle, wr_en, state_r == pirr_pkg::T_IDLE, "table write during a search")
  `PIRR_ASSERT_IMPL(a_start_idle, req.start, state_r == pirr_pkg::T_IDLE, "search start while busy")
  `PIRR_ASSERT_IMPL(a_cmp_span, state_r == pirr_pkg::T_CMP, lo_r < hi_r, "compare on an empty span")
  `PIRR_ASSERT_IMPL(a_last_span, state_r == pirr_pkg::T_LAST, lo_r == hi_r, "search ended unconverged")

endmodule
